[hdl/fmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types and constants for the feature map pooling unit.
// ----------------------------------------------------------------------------
package fmp_pkg;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 13;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MAP_WIDTH   = 3'd0,
        REG_MAP_HEIGHT  = 3'd1,
        REG_MAP_COUNT   = 3'd2,
        REG_WINDOW_SIZE = 3'd3,
        REG_STEP_SIZE   = 3'd4,
        REG_POOL_MODE   = 3'd5
    } t_cfg_idx;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    localparam int unsigned MAP_BITS = 12;
    localparam int unsigned ROW_BITS = 12;
    localparam int unsigned OCOL_BITS = 10;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // capture pixel, start column fetch
        logic       shift;    // shift window, write line store
        logic       acc_clr;  // start a window reduction
        logic       acc_row;  // fold one window row
        logic       finish;   // divide/format result into output reg
    } t_dp_cmd;
endpackage

[hdl/fmp_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface fmp_stream_if #(
    parameter int unsigned W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/fmp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_datapath
// Line store, window registers, row-serial reducer and averaging divider.
// ----------------------------------------------------------------------------
module fmp_datapath #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_WIN    = 4,
    parameter int unsigned PIXEL_BITS = 16,
    parameter int unsigned CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int unsigned KB = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1,
    parameter int unsigned WB = $clog2(MAX_WIN + 1)
) (
    input  logic                         i_clk,
    input  fmp_pkg::t_dp_cmd             i_cmd,
    input  logic signed [PIXEL_BITS-1:0] i_pixel,
    input  logic [CB-1:0]                i_col,
    input  logic [KB-1:0]                i_krow,
    input  logic [WB-1:0]                i_win,
    input  logic                         i_mode,
    output logic signed [PIXEL_BITS-1:0] o_result
);
    import fmp_pkg::*;

    localparam int unsigned SB = PIXEL_BITS + 2 * WB;
    localparam int unsigned DB = 2 * WB;
    localparam int unsigned RK = SB + 6;

    logic signed [PIXEL_BITS-1:0] r_mem [MAX_WIN-1][MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] r_rd [MAX_WIN-1];
    logic signed [PIXEL_BITS-1:0] r_px;
    logic signed [PIXEL_BITS-1:0] r_win [MAX_WIN][MAX_WIN];
    logic signed [SB-1:0]         r_acc;
    logic signed [SB-1:0]         n_acc;
    logic signed [PIXEL_BITS-1:0] r_result;
    logic signed [SB-1:0]         row_sum;
    logic signed [PIXEL_BITS-1:0] row_max;
    logic [SB-1:0]                mag;
    logic [SB-1:0]                quo;
    logic [DB-1:0]                div;
    logic [RK:0]                  recip;
    logic [SB+RK:0]               prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel;
            for (int k = 0; k < MAX_WIN - 1; k++) begin
                r_rd[k] <= r_mem[k][i_col];
            end
        end
        if (i_cmd.shift) begin
            r_mem[0][i_col] <= r_px;
            for (int k = 1; k < MAX_WIN - 1; k++) begin
                r_mem[k][i_col] <= r_rd[k-1];
            end
            for (int k = 0; k < MAX_WIN; k++) begin
                for (int j = MAX_WIN - 1; j >= 1; j--) begin
                    r_win[k][j] <= r_win[k][j-1];
                end
            end
            r_win[0][0] <= r_px;
            for (int k = 1; k < MAX_WIN; k++) begin
                r_win[k][0] <= r_rd[k-1];
            end
        end
    end

    always_comb begin
        row_sum = '0;
        row_max = {1'b1, {(PIXEL_BITS-1){1'b0}}};
        for (int j = 0; j < MAX_WIN; j++) begin
            if (WB'(j) < i_win) begin
                row_sum = row_sum + SB'(r_win[i_krow][j]);
                if (r_win[i_krow][j] > row_max) begin
                    row_max = r_win[i_krow][j];
                end
            end
        end
        n_acc = r_acc;
        if (i_mode == MODE_AVG) begin
            n_acc = r_acc + row_sum;
        end else if (SB'(row_max) > r_acc) begin
            n_acc = SB'(row_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= (i_mode == MODE_AVG) ? '0
                   : SB'(signed'({1'b1, {(PIXEL_BITS-1){1'b0}}}));
        end else if (i_cmd.acc_row) begin
            r_acc <= n_acc;
        end
    end

    // window area is at most MAX_WIN^2; divide magnitude by reciprocal multiply
    assign div = DB'(i_win) * DB'(i_win);
    assign mag = r_acc[SB-1] ? SB'(-r_acc) : SB'(r_acc);

    always_comb begin
        recip = '0;
        for (int d = 1; d <= MAX_WIN; d++) begin
            if (WB'(d) == i_win) begin
                recip = (RK+1)'(((64'd1 << RK) + 64'(d * d) - 64'd1) / 64'(d * d));
            end
        end
        prod = (SB+RK+1)'(mag) * (SB+RK+1)'(recip);
        quo = SB'(prod >> RK);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (i_mode == MODE_AVG && div != '0) begin
                r_result <= r_acc[SB-1] ? PIXEL_BITS'(-quo) : PIXEL_BITS'(quo);
            end else begin
                r_result <= PIXEL_BITS'(r_acc);
            end
        end
    end

    assign o_result = r_result;
endmodule

[hdl/fmp_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_controller
// Stream position, window test and sequencing of one pixel per beat.
// ----------------------------------------------------------------------------
module fmp_controller #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned MAX_WIN   = 4,
    parameter int unsigned CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int unsigned KB = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1,
    parameter int unsigned WB = $clog2(MAX_WIN + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fmp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [fmp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fmp_pkg::t_dp_cmd            o_cmd,
    output logic [CB-1:0]               o_col,
    output logic [KB-1:0]               o_krow,
    output logic [WB-1:0]               o_win,
    output logic                        o_mode,
    output logic [fmp_pkg::MAP_BITS-1:0]  o_map_index,
    output logic [fmp_pkg::ROW_BITS-1:0]  o_out_row,
    output logic [fmp_pkg::OCOL_BITS-1:0] o_out_col,
    output logic                        o_layer_last
);
    import fmp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_REDUCE = 5'b00100,
        S_FINISH = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [10:0] r_w;
    logic [12:0] r_h, r_n;
    logic [2:0]  r_win_raw, r_step_raw;
    logic        r_mode;
    logic [CB:0] r_c;
    logic [12:0] r_r;
    logic [12:0] r_m;
    logic [KB:0] r_k;
    logic        r_hit;
    logic        r_out_v;
    logic [MAP_BITS-1:0]  r_omap;
    logic [ROW_BITS-1:0]  r_orow;
    logic [OCOL_BITS-1:0] r_ocol;
    logic        r_olast;
    logic [2:0]  r_tph, r_lph;
    logic [ROW_BITS-1:0]  r_tq;
    logic [OCOL_BITS-1:0] r_lq;
    logic [CB:0]  w_eff;
    logic [12:0]  h_eff, n_eff;
    logic [WB-1:0] win;
    logic [2:0]   step;
    logic [CB:0]  c_eff;
    logic [12:0]  top;
    logic [CB:0]  left;
    logic         hit;
    logic         last;
    logic         acc;
    logic         out_free;

    always_comb begin
        w_eff = (r_w == '0) ? (CB+1)'(1)
              : (32'(r_w) > MAX_WIDTH) ? (CB+1)'(MAX_WIDTH) : (CB+1)'(r_w);
        h_eff = (r_h == '0) ? 13'd1 : (r_h > 13'd4096) ? 13'd4096 : r_h;
        n_eff = (r_n == '0) ? 13'd1 : (r_n > 13'd4096) ? 13'd4096 : r_n;
        win = (r_win_raw == '0) ? WB'(1)
            : (32'(r_win_raw) > MAX_WIN) ? WB'(MAX_WIN) : WB'(r_win_raw);
        step = (r_step_raw == '0) ? 3'd1 : r_step_raw;
        c_eff = (r_c >= w_eff) ? w_eff - 1'b1 : r_c;
        top = r_r + 13'd1 - 13'(win);
        left = c_eff + 1'b1 - (CB+1)'(win);
        hit = (r_r + 13'd1 >= 13'(win)) && (c_eff + 1'b1 >= (CB+1)'(win))
            && (w_eff >= (CB+1)'(win)) && (h_eff >= 13'(win))
            && (r_tph == '0) && (r_lph == '0);
        last = (r_m + 13'd1 == n_eff)
            && (14'(top) + 14'(step) + 14'(win) > 14'(h_eff))
            && ((CB+2)'(left) + (CB+2)'(step) + (CB+2)'(win) > (CB+2)'(w_eff));
    end

    assign acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_we;
    assign out_free = !r_out_v || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (acc) n_state = S_SHIFT;
            S_SHIFT:  n_state = r_hit ? S_REDUCE : S_IDLE;
            S_REDUCE: if (r_k == (KB+1)'(win) - 1'b1) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w <= 11'd1; r_h <= 13'd1; r_n <= 13'd1;
            r_win_raw <= 3'd2; r_step_raw <= 3'd2; r_mode <= MODE_MAX;
            r_c <= '0; r_r <= '0; r_m <= '0; r_k <= '0;
            r_tph <= '0; r_tq <= '0; r_lph <= '0; r_lq <= '0;
            r_hit <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAP_WIDTH:   r_w <= i_cfg_data[10:0];
                    REG_MAP_HEIGHT:  r_h <= i_cfg_data;
                    REG_MAP_COUNT:   r_n <= i_cfg_data;
                    REG_WINDOW_SIZE: r_win_raw <= i_cfg_data[2:0];
                    REG_STEP_SIZE:   r_step_raw <= i_cfg_data[2:0];
                    REG_POOL_MODE:   r_mode <= i_cfg_data[0];
                    default: ;
                endcase
                if (i_cfg_idx <= REG_POOL_MODE) begin
                    r_c <= '0; r_r <= '0; r_m <= '0;
                    r_tph <= '0; r_tq <= '0; r_lph <= '0; r_lq <= '0;
                end
            end
            if (acc) begin
                r_hit <= hit;
                r_omap <= r_m[MAP_BITS-1:0];
                r_orow <= r_tq;
                r_ocol <= r_lq;
                r_olast <= last;
                if (c_eff + 1'b1 >= w_eff) begin
                    r_c <= '0;
                    r_lph <= '0;
                    r_lq <= '0;
                    if (r_r + 13'd1 >= h_eff) begin
                        r_r <= '0;
                        r_tph <= '0;
                        r_tq <= '0;
                        r_m <= (r_m + 13'd1 >= n_eff) ? '0 : r_m + 13'd1;
                    end else begin
                        r_r <= r_r + 13'd1;
                        if (r_r + 13'd2 <= 13'(win)) begin
                            r_tph <= '0;
                            r_tq <= '0;
                        end else if (r_tph + 3'd1 >= step) begin
                            r_tph <= '0;
                            r_tq <= r_tq + 1'b1;
                        end else begin
                            r_tph <= r_tph + 3'd1;
                        end
                    end
                end else begin
                    r_c <= c_eff + 1'b1;
                    if (c_eff + (CB+1)'(2) <= (CB+1)'(win)) begin
                        r_lph <= '0;
                        r_lq <= '0;
                    end else if (r_lph + 3'd1 >= step) begin
                        r_lph <= '0;
                        r_lq <= r_lq + 1'b1;
                    end else begin
                        r_lph <= r_lph + 3'd1;
                    end
                end
            end
            if (r_state == S_SHIFT) r_k <= '0;
            if (r_state == S_REDUCE) r_k <= r_k + 1'b1;
            if (r_state == S_OUT && out_free) begin
                r_out_v <= 1'b1;
                o_map_index <= r_omap; o_out_row <= r_orow;
                o_out_col <= r_ocol; o_layer_last <= r_olast;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load = acc;
        o_cmd.shift = (r_state == S_SHIFT);
        o_cmd.acc_clr = (r_state == S_SHIFT);
        o_cmd.acc_row = (r_state == S_REDUCE);
        o_cmd.finish = (r_state == S_FINISH) && out_free;
    end

    assign o_col = (r_state == S_IDLE) ? c_eff[CB-1:0]
                 : ((r_c == '0) ? CB'(w_eff - 1'b1) : CB'(r_c - 1'b1));
    assign o_krow = r_k[KB-1:0];
    assign o_win = win;
    assign o_mode = r_mode;
    assign o_out_valid = r_out_v;
endmodule

[hdl/feature_map_pooling_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_map_pooling_unit
// Streaming 2-D max/average pooling over raster-order feature maps.
//
//   channel   dir  payload
//   s_in      in   pixel
//   m_out     out  pooled, map_index, out_row, out_col, layer_last
//   cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// A beat without a result passes the idle and shift states; a beat closing a
// window also runs the row-serial reducer over its rows, then finish and out.
// Synchronous active-low reset; line store is not cleared.
// The result register holds until taken; a beat closing a window holds in
// its finish state until the previous result is taken.
// ----------------------------------------------------------------------------
module feature_map_pooling_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_WIN    = 4,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [fmp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [fmp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    fmp_stream_if.sink   s_in,
    fmp_stream_if.source m_out
);
    import fmp_pkg::*;

    localparam int unsigned CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned KB = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
    localparam int unsigned WB = $clog2(MAX_WIN + 1);

    t_dp_cmd cmd;
    logic [CB-1:0] col;
    logic [KB-1:0] krow;
    logic [WB-1:0] win;
    logic mode;
    logic signed [PIXEL_BITS-1:0] result;
    logic [MAP_BITS-1:0] map_index;
    logic [ROW_BITS-1:0] out_row;
    logic [OCOL_BITS-1:0] out_col;
    logic layer_last;

    fmp_controller #(.MAX_WIDTH(MAX_WIDTH), .MAX_WIN(MAX_WIN)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .o_cmd(cmd), .o_col(col), .o_krow(krow), .o_win(win), .o_mode(mode),
        .o_map_index(map_index), .o_out_row(out_row), .o_out_col(out_col),
        .o_layer_last(layer_last)
    );

    fmp_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_WIN(MAX_WIN),
                   .PIXEL_BITS(PIXEL_BITS)) u_dp (
        .i_clk, .i_cmd(cmd), .i_pixel(s_in.data[PIXEL_BITS-1:0]),
        .i_col(col), .i_krow(krow), .i_win(win), .i_mode(mode),
        .o_result(result)
    );

    assign m_out.data = {result, map_index, out_row, out_col, layer_last};
endmodule
